[design/pcc_pkg.sv]
`timescale 1ns / 1ps
package pcc_pkg;
  localparam int MaxVectors = 64;
  localparam int ComponentBits = 24;
  localparam logic [15:0] HalfScale = 16'd16384;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQRT, ST_CHECK, ST_LOAD, ST_MUL, ST_ACC, ST_DIV, ST_EMIT, ST_STORE, ST_DROP
  } pcc_state_t;

  typedef struct packed {
    logic start_sqrt;
    logic load_entry;
    logic mul_step;
    logic start_div;
    logic emit;
    logic store;
    logic next_entry;
    logic clear;
    logic drop;
  } pcc_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic mul_done;
    logic full;
    logic empty;
    logic last_entry;
    logic out_busy;
    logic eoe;
  } pcc_status_t;
endpackage

[design/pcc_if.sv]
`timescale 1ns / 1ps
interface pcc_in_if #(parameter int ComponentBits = pcc_pkg::ComponentBits);
  logic valid;
  logic ready;
  logic signed [ComponentBits-1:0] mom_x;
  logic signed [ComponentBits-1:0] mom_y;
  logic signed [ComponentBits-1:0] mom_z;
  logic end_of_event;
  modport source (output valid, mom_x, mom_y, mom_z, end_of_event, input ready);
  modport sink (input valid, mom_x, mom_y, mom_z, end_of_event, output ready);
endinterface

interface pcc_out_if;
  logic valid;
  logic ready;
  logic [5:0] first_index;
  logic [5:0] second_index;
  logic signed [15:0] coupling;
  logic zero_norm;
  logic dropped;
  logic last_of_run;
  modport source (output valid, first_index, second_index, coupling, zero_norm, dropped,
                  last_of_run, input ready);
  modport sink (input valid, first_index, second_index, coupling, zero_norm, dropped,
                last_of_run, output ready);
endinterface

[design/pcc_ctrl.sv]
`timescale 1ns / 1ps
module pcc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pcc_pkg::pcc_status_t status,
  output pcc_pkg::pcc_cmd_t cmd
);
  pcc_pkg::pcc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= pcc_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      pcc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start_sqrt = 1'b1;
          state_next = pcc_pkg::ST_SQRT;
        end
      end
      pcc_pkg::ST_SQRT: if (status.sqrt_done) state_next = pcc_pkg::ST_CHECK;
      pcc_pkg::ST_CHECK: begin
        if (status.full) state_next = pcc_pkg::ST_DROP;
        else if (status.empty) state_next = pcc_pkg::ST_STORE;
        else state_next = pcc_pkg::ST_LOAD;
      end
      pcc_pkg::ST_LOAD: begin
        cmd.load_entry = 1'b1;
        state_next = pcc_pkg::ST_MUL;
      end
      pcc_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_done) state_next = pcc_pkg::ST_ACC;
      end
      pcc_pkg::ST_ACC: begin
        cmd.start_div = 1'b1;
        state_next = pcc_pkg::ST_DIV;
      end
      pcc_pkg::ST_DIV: if (status.div_done) state_next = pcc_pkg::ST_EMIT;
      pcc_pkg::ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          if (status.last_entry) state_next = pcc_pkg::ST_STORE;
          else begin
            cmd.next_entry = 1'b1;
            state_next = pcc_pkg::ST_LOAD;
          end
        end
      end
      pcc_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        cmd.clear = status.eoe;
        state_next = pcc_pkg::ST_IDLE;
      end
      pcc_pkg::ST_DROP: begin
        if (!status.out_busy) begin
          cmd.drop = 1'b1;
          cmd.clear = status.eoe;
          state_next = pcc_pkg::ST_IDLE;
        end
      end
      default: state_next = pcc_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_emit_idle_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_busy) else $error("emit into busy output");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == pcc_pkg::ST_IDLE) else $error("ready outside idle");
  a_store_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> state == pcc_pkg::ST_IDLE) else $error("store not followed by idle");
`endif
endmodule

[design/pcc_datapath.sv]
`timescale 1ns / 1ps
module pcc_datapath #(
  parameter int MaxVectors = pcc_pkg::MaxVectors,
  parameter int ComponentBits = pcc_pkg::ComponentBits
) (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic signed [ComponentBits-1:0] mom_x,
  input  logic signed [ComponentBits-1:0] mom_y,
  input  logic signed [ComponentBits-1:0] mom_z,
  input  logic end_of_event,
  input  pcc_pkg::pcc_cmd_t cmd,
  output pcc_pkg::pcc_status_t status,
  pcc_out_if.source out
);
  localparam int AddrBits = $clog2(MaxVectors);
  localparam int CntBits = $clog2(MaxVectors + 1);
  localparam int SqBits = 2 * ComponentBits + 2;
  localparam int NormBits = ComponentBits + 1;
  localparam int ProdBits = 2 * ComponentBits;
  localparam int DotBits = 2 * ComponentBits + 2;
  localparam int DenBits = 2 * NormBits;
  localparam int SqIter = SqBits / 2;
  localparam int SqCntBits = $clog2(SqIter + 1);
  localparam int DivIter = DotBits + 15;
  localparam int DivCntBits = $clog2(DivIter + 1);

  logic signed [ComponentBits-1:0] mem_x [MaxVectors];
  logic signed [ComponentBits-1:0] mem_y [MaxVectors];
  logic signed [ComponentBits-1:0] mem_z [MaxVectors];
  logic [NormBits-1:0] mem_n [MaxVectors];

  logic signed [ComponentBits-1:0] cur_x, cur_y, cur_z;
  logic eoe;
  logic [CntBits-1:0] count;
  logic [AddrBits-1:0] idx;

  // Norm: sum of squares built one component a cycle, then a bit-pair square root.
  logic [1:0] sq_phase;
  logic sq_sum_busy, sq_busy;
  logic [SqBits-1:0] sq_rem;
  logic [NormBits:0] sq_root;
  logic [SqBits-1:0] sq_src;
  logic [SqCntBits-1:0] sq_cnt;
  logic [NormBits-1:0] norm;
  logic signed [ComponentBits-1:0] sq_op;
  logic signed [ProdBits-1:0] sq_prod;
  logic [SqBits+1:0] sq_trial;
  logic [SqBits+1:0] sq_remsh;

  always_comb begin
    case (sq_phase)
      2'd0: sq_op = cur_x;
      2'd1: sq_op = cur_y;
      default: sq_op = cur_z;
    endcase
    sq_prod = sq_op * sq_op;
    sq_remsh = {sq_rem, sq_src[SqBits-1 -: 2]};
    sq_trial = (SqBits+2)'({sq_root[NormBits-1:0], 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_sum_busy <= 1'b0;
      sq_busy <= 1'b0;
    end else if (cmd.start_sqrt) begin
      sq_sum_busy <= 1'b1;
      sq_phase <= 2'd0;
      sq_src <= '0;
    end else if (sq_sum_busy) begin
      sq_src <= sq_src + SqBits'(unsigned'(sq_prod));
      sq_phase <= sq_phase + 2'd1;
      if (sq_phase == 2'd2) begin
        sq_sum_busy <= 1'b0;
        sq_busy <= 1'b1;
        sq_rem <= '0;
        sq_root <= '0;
        sq_cnt <= '0;
      end
    end else if (sq_busy) begin
      sq_src <= sq_src << 2;
      if (sq_remsh >= sq_trial) begin
        sq_rem <= SqBits'(sq_remsh - sq_trial);
        sq_root <= {sq_root[NormBits-1:0], 1'b1};
      end else begin
        sq_rem <= SqBits'(sq_remsh);
        sq_root <= {sq_root[NormBits-1:0], 1'b0};
      end
      sq_cnt <= sq_cnt + 1'b1;
      if (sq_cnt == SqCntBits'(SqIter - 1)) sq_busy <= 1'b0;
    end
  end

  // Round to nearest: the remainder exceeding the root adds one.
  assign norm = (SqBits'(sq_rem) > SqBits'(sq_root)) ? NormBits'(sq_root + 1'b1)
                                                      : NormBits'(sq_root);
  logic sq_done_flag;
  always_ff @(posedge clk) begin
    if (rst) sq_done_flag <= 1'b0;
    else sq_done_flag <= sq_busy && (sq_cnt == SqCntBits'(SqIter - 1));
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_x <= mom_x;
      cur_y <= mom_y;
      cur_z <= mom_z;
      eoe <= end_of_event;
    end
  end

  // Store read, registered.
  logic signed [ComponentBits-1:0] rd_x, rd_y, rd_z;
  logic [NormBits-1:0] rd_n;
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem_x[count[AddrBits-1:0]] <= cur_x;
      mem_y[count[AddrBits-1:0]] <= cur_y;
      mem_z[count[AddrBits-1:0]] <= cur_z;
      mem_n[count[AddrBits-1:0]] <= norm;
    end
    rd_x <= mem_x[idx];
    rd_y <= mem_y[idx];
    rd_z <= mem_z[idx];
    rd_n <= mem_n[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx <= '0;
    end else begin
      if (cmd.clear) count <= '0;
      else if (cmd.store) count <= count + 1'b1;
      if (cmd.store || cmd.drop) idx <= '0;
      else if (cmd.next_entry) idx <= idx + 1'b1;
    end
  end

  // Dot product: one component product a cycle, then the norm product.
  logic [1:0] mul_phase;
  logic signed [DotBits-1:0] dot;
  logic signed [ComponentBits-1:0] ma, mb;
  logic signed [ProdBits-1:0] mprod;
  logic [DenBits-1:0] den;
  always_comb begin
    case (mul_phase)
      2'd0: begin ma = rd_x; mb = cur_x; end
      2'd1: begin ma = rd_y; mb = cur_y; end
      default: begin ma = rd_z; mb = cur_z; end
    endcase
    mprod = ma * mb;
  end
  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      mul_phase <= 2'd0;
      dot <= '0;
    end else if (cmd.mul_step) begin
      mul_phase <= mul_phase + 2'd1;
      if (mul_phase != 2'd3) dot <= dot + DotBits'(mprod);
      else den <= DenBits'(rd_n * norm);
    end
  end

  // Restoring divide: quotient of |dot|*2^15 / den, one bit a cycle.
  logic [DotBits-1:0] dmag;
  logic dneg, zn;
  logic [DenBits:0] drem;
  logic [DotBits+14:0] dnum;
  logic [15:0] dq;
  logic div_busy, div_done_flag;
  logic [DivCntBits-1:0] div_cnt;
  logic [DenBits+1:0] dtrial;
  logic sat;
  assign dtrial = {drem, dnum[DotBits+14]};
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done_flag <= 1'b0;
    end else begin
      div_done_flag <= 1'b0;
      if (cmd.start_div) begin
        div_busy <= 1'b1;
        div_cnt <= '0;
        drem <= '0;
        dq <= '0;
        sat <= 1'b0;
        dneg <= dot[DotBits-1];
        dmag <= dot[DotBits-1] ? DotBits'(-dot) : DotBits'(dot);
        dnum <= {(dot[DotBits-1] ? DotBits'(-dot) : DotBits'(dot)), 15'd0};
        zn <= (rd_n == '0) || (norm == '0);
      end else if (div_busy) begin
        dnum <= dnum << 1;
        if (dtrial >= (DenBits+2)'(den)) begin
          drem <= (DenBits+1)'(dtrial - (DenBits+2)'(den));
          if (div_cnt < DivCntBits'(DotBits)) sat <= 1'b1;
          else dq <= {dq[14:0], 1'b1};
        end else begin
          drem <= (DenBits+1)'(dtrial);
          if (div_cnt >= DivCntBits'(DotBits)) dq <= {dq[14:0], 1'b0};
        end
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == DivCntBits'(DivIter - 1)) begin
          div_busy <= 1'b0;
          div_done_flag <= 1'b1;
        end
      end
    end
  end

  logic [16:0] mag_r;
  logic [15:0] mag;
  always_comb begin
    mag_r = ({1'b0, dq} + 17'd1) >> 1;
    if (sat || mag_r > 17'(pcc_pkg::HalfScale)) mag = pcc_pkg::HalfScale;
    else mag = mag_r[15:0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (cmd.emit || cmd.drop) out.valid <= 1'b1;
    else if (out.ready) out.valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out.first_index <= 6'(idx);
      out.second_index <= 6'(count);
      out.zero_norm <= zn;
      if (zn || dmag == '0) out.coupling <= '0;
      else out.coupling <= dneg ? mag : 16'(-mag);
      out.dropped <= 1'b0;
      out.last_of_run <= (CntBits'(idx) + 1'b1 == count);
    end else if (cmd.drop) begin
      out.first_index <= '0;
      out.second_index <= '0;
      out.coupling <= '0;
      out.zero_norm <= 1'b0;
      out.dropped <= 1'b1;
      out.last_of_run <= 1'b1;
    end
  end

  assign status.sqrt_done = sq_done_flag;
  assign status.div_done = div_done_flag;
  assign status.mul_done = (mul_phase == 2'd3);
  assign status.full = (count >= CntBits'(MaxVectors));
  assign status.empty = (count == '0);
  assign status.last_entry = (CntBits'(idx) + 1'b1 == count);
  assign status.out_busy = out.valid && !out.ready;
  assign status.eoe = eoe;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntBits'(MaxVectors)) else $error("count beyond capacity");
  a_idx_below: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> CntBits'(idx) < count) else $error("index past fill");
  a_zero_coup: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.zero_norm |-> out.coupling == '0) else $error("zero norm with coupling");
`endif
endmodule

[design/pairwise_cosine_coupling_top.sv]
`timescale 1ns / 1ps
// Pairwise cosine coupling of 3-D momentum vectors.
// in_ch carries one momentum vector a beat plus an end-of-event mark; out_ch
// carries one beat per earlier vector of the event: both indices, the Q1.15
// coupling -0.5*cos, and zero-norm, dropped and last-of-run flags.
// A vector arriving on a full store is discarded and one dropped beat follows.
// The first vector of an event gives no beat.
// An item passes from its accepting edge through its norm (the sum of squares,
// the bit-pair square root and a registered done flag) and the check state;
// then for each stored vector through loading and product accumulation, the
// serial divider and the emit of its beat; then through store and idle.
// A dropped beat follows the norm, the check and the drop state.
// One item is handled at a time; in_ch.ready is high only when idle.
// Reset clears the vector count and output valid; the store itself is
// not cleared, entries beyond the count are never used.
// When out_ch stalls the walk waits with the next beat held back; the
// output register holds its beat until taken.
module pairwise_cosine_coupling_top #(
  parameter int MaxVectors = pcc_pkg::MaxVectors,
  parameter int ComponentBits = pcc_pkg::ComponentBits
) (
  input logic clk,
  input logic rst,
  pcc_in_if.sink in_ch,
  pcc_out_if.source out_ch
);
  pcc_pkg::pcc_cmd_t cmd;
  pcc_pkg::pcc_status_t status;

  pcc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .status(status), .cmd(cmd)
  );

  pcc_datapath #(.MaxVectors(MaxVectors), .ComponentBits(ComponentBits)) u_dp (
    .clk(clk), .rst(rst), .in_fire(in_ch.valid && in_ch.ready),
    .mom_x(in_ch.mom_x), .mom_y(in_ch.mom_y), .mom_z(in_ch.mom_z),
    .end_of_event(in_ch.end_of_event), .cmd(cmd), .status(status), .out(out_ch)
  );
endmodule

[dv/pairwise_cosine_coupling_top_tb.sv]
`timescale 1ns / 1ps
module pairwise_cosine_coupling_top_tb;

  typedef struct {
    logic [5:0] first_index;
    logic [5:0] second_index;
    logic [15:0] coupling;
    logic zero_norm;
    logic dropped;
    logic last_of_run;
  } pair_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcc_in_if in_ch ();
  pcc_out_if out_ch ();

  pairwise_cosine_coupling_top u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  // Predictor state: the momentum store of the current event.
  longint ev_x [pcc_pkg::MaxVectors];
  longint ev_y [pcc_pkg::MaxVectors];
  longint ev_z [pcc_pkg::MaxVectors];
  longint unsigned ev_norm [pcc_pkg::MaxVectors];
  int unsigned ev_count;

  pair_beat_t pending_pairs[$];
  int unsigned errors;
  int unsigned vectors_sent;
  int unsigned beats_checked;
  int unsigned drops_seen;
  int unsigned zero_norm_seen;
  int max_gap;
  int max_stall;
  int stall_left;

  function automatic longint unsigned rounded_norm(longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (s > res) res++;
    return res;
  endfunction

  function automatic logic [15:0] pair_coupling(int unsigned i, longint x, longint y, longint z,
                                                 longint unsigned n);
    longint dot;
    longint unsigned d, den, r, q, m;
    logic neg_dot;
    dot = ev_x[i] * x + ev_y[i] * y + ev_z[i] * z;
    neg_dot = dot < 0;
    d = neg_dot ? -dot : dot;
    if (d == 0) return 16'd0;
    den = ev_norm[i] * n;
    if (d / den >= 1) begin
      m = pcc_pkg::HalfScale;
    end else begin
      r = d % den;
      q = 0;
      for (int k = 0; k < 15; k++) begin
        q <<= 1;
        if (r >= den - r) begin
          r -= den - r;
          q |= 1;
        end else begin
          r += r;
        end
      end
      m = (q + 1) >> 1;
      if (m > pcc_pkg::HalfScale) m = pcc_pkg::HalfScale;
    end
    // A positive dot product gives a negative coupling.
    return neg_dot ? m[15:0] : 16'(17'h10000 - m);
  endfunction

  task automatic predict_pairs(longint x, longint y, longint z, logic eoe);
    pair_beat_t b;
    longint unsigned n;
    n = rounded_norm(x * x + y * y + z * z);
    if (ev_count >= pcc_pkg::MaxVectors) begin
      b = '{6'd0, 6'd0, 16'd0, 1'b0, 1'b1, 1'b1};
      pending_pairs.insert(pending_pairs.size(), b);
    end else begin
      for (int unsigned i = 0; i < ev_count; i++) begin
        b.first_index = i[5:0];
        b.second_index = ev_count[5:0];
        b.zero_norm = (ev_norm[i] == 0) || (n == 0);
        b.coupling = b.zero_norm ? 16'd0 : pair_coupling(i, x, y, z, n);
        b.dropped = 1'b0;
        b.last_of_run = (i + 1 == ev_count);
        pending_pairs.insert(pending_pairs.size(), b);
      end
      ev_x[ev_count] = x;
      ev_y[ev_count] = y;
      ev_z[ev_count] = z;
      ev_norm[ev_count] = n;
      ev_count++;
    end
    if (eoe) ev_count = 0;
  endtask

  task automatic send_vector(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic eoe);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mom_x <= x;
    in_ch.mom_y <= y;
    in_ch.mom_z <= z;
    in_ch.end_of_event <= eoe;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_pairs(longint'($signed(x)), longint'($signed(y)), longint'($signed(z)), eoe);
    vectors_sent++;
  endtask

  task automatic drain_pairs();
    in_ch.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  always @(posedge clk) begin
    pair_beat_t e;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (out_ch.dropped) drops_seen++;
        if (out_ch.zero_norm) zero_norm_seen++;
        if (pending_pairs.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat %0d/%0d coupling %0d", $time,
                   out_ch.first_index, out_ch.second_index, out_ch.coupling);
        end else begin
          e = pending_pairs.pop_front();
          if (e.first_index !== out_ch.first_index || e.second_index !== out_ch.second_index
              || e.coupling !== out_ch.coupling || e.zero_norm !== out_ch.zero_norm
              || e.dropped !== out_ch.dropped || e.last_of_run !== out_ch.last_of_run) begin
            errors++;
            $display("%0t: expected idx %0d/%0d coup %0d zn %b dr %b last %b", $time,
                     e.first_index, e.second_index, $signed(e.coupling), e.zero_norm,
                     e.dropped, e.last_of_run);
            $display("%0t: actual   idx %0d/%0d coup %0d zn %b dr %b last %b", $time,
                     out_ch.first_index, out_ch.second_index, out_ch.coupling,
                     out_ch.zero_norm, out_ch.dropped, out_ch.last_of_run);
          end
        end
        stall_left = $urandom_range(0, max_stall);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_extremes();
    send_vector(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_vector(24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_vector(24'h7FFFFF, 24'h800000, 24'h000001, 1'b0);
    send_vector(24'h000000, 24'h000000, 24'h000000, 1'b0);
    send_vector(24'hFFFFFF, 24'h000000, 24'h000000, 1'b1);
    // A lone vector with end of event gives no beat.
    send_vector(24'h000100, 24'h000200, 24'h000300, 1'b1);
  endtask

  task automatic test_zero_dot();
    send_vector(24'd1000, 24'd0, 24'd0, 1'b0);
    send_vector(24'd0, 24'd777, 24'd0, 1'b0);
    send_vector(24'd3, 24'd4, -24'sd5, 1'b0);
    send_vector(24'd1, 24'd1, 24'd0, 1'b1);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < pcc_pkg::MaxVectors; i++)
      send_vector(24'($urandom_range(0, 2000)) - 24'd1000, 24'($urandom_range(0, 2000)),
                  24'(i) - 24'd30, 1'b0);
    send_vector(24'd5, 24'd6, 24'd7, 1'b0);
    send_vector(24'd5, 24'd6, 24'd7, 1'b1);
    // End of event on an empty store.
    send_vector(24'd0, 24'd0, 24'd0, 1'b1);
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned sent;
    int len;
    int mode;
    logic [23:0] x, y, z, px, py, pz;
    sent = 0;
    px = 24'd1;
    py = 24'd2;
    pz = 24'd3;
    while (sent < n_items) begin
      if (sent > n_items / 2 && sent < n_items / 2 + 8) begin
        max_gap = 0;
        max_stall = 0;
      end else begin
        max_gap = 5;
        max_stall = 5;
      end
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
      for (int k = 0; k < len; k++) begin
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
        end else if (mode < 7) begin
          x = 24'($urandom_range(0, 600)) - 24'd300;
          y = 24'($urandom_range(0, 600)) - 24'd300;
          z = 24'($urandom_range(0, 600)) - 24'd300;
        end else if (mode == 7) begin
          x = 24'd0;
          y = 24'd0;
          z = 24'd0;
        end else if (mode == 8) begin
          x = px << 1;
          y = py << 1;
          z = pz << 1;
        end else begin
          x = -px;
          y = -py;
          z = -pz;
        end
        send_vector(x, y, z, k == len - 1);
        px = x;
        py = y;
        pz = z;
        sent++;
      end
      if (sent >= n_items / 3 && sent < n_items / 3 + len) begin
        // Hold off until everything expected has come out.
        in_ch.valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    ev_count = 0;
    errors = 0;
    vectors_sent = 0;
    beats_checked = 0;
    drops_seen = 0;
    zero_norm_seen = 0;
    stall_left = 0;
    max_gap = 5;
    max_stall = 5;
    in_ch.valid = 1'b0;
    in_ch.mom_x = '0;
    in_ch.mom_y = '0;
    in_ch.mom_z = '0;
    in_ch.end_of_event = 1'b0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_zero_dot();
    test_full_store();
    test_random(45);
    drain_pairs();
    $display("Sent %0d vectors, checked %0d beats (%0d dropped, %0d zero-norm).",
             vectors_sent, beats_checked, drops_seen, zero_norm_seen);
    $display("Covered extremes, orthogonal pairs, a full store and random events.");
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

[sim.f]
design/pcc_pkg.sv
design/pcc_if.sv
design/pcc_ctrl.sv
design/pcc_datapath.sv
design/pairwise_cosine_coupling_top.sv
dv/pairwise_cosine_coupling_top_tb.sv
